### rtl/gcyi_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the gyro calibration and yaw integration block
// no dependencies

package gcyi_pkg;

  // item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // configuration register indexes
  localparam logic CFG_TICK_SCALE = 1'b0;
  localparam logic CFG_FLAT_MODE  = 1'b1;

  // register reset values
  localparam logic [31:0] TICK_SCALE_RST = 32'd1501760;
  localparam logic        FLAT_MODE_RST  = 1'b1;

  // step saturation limit
  localparam int STEP_LIMIT = 1048576;

  // divider and sequencer widths and iteration counts
  localparam int DVD_W    = 70;
  localparam int DVS_W    = 42;
  localparam int QUO_W    = 31;
  localparam int CNT_W    = 7;
  localparam int RATIO_IT = 70;
  localparam int SQRT_IT  = 16;
  localparam int SCALE_IT = 32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CAL_SQ,
    S_CAL_TOT,
    S_CAL_AX,
    S_CAL_DIV,
    S_CAL_SQRT,
    S_T_DZ0,
    S_T_DZ1,
    S_T_FLAT,
    S_T_X0,
    S_T_X1,
    S_T_Y0,
    S_T_Y1,
    S_T_Z,
    S_T_ABS,
    S_T_SCALE,
    S_T_SAT,
    S_T_DIV,
    S_T_FIN,
    S_DONE
  } state_t;

endpackage

### rtl/gyro_calibrate_yaw_integrate.sv
`timescale 1ns / 1ps
// gyro bias calibration and yaw integration, single sequenced datapath
// depends on gcyi_pkg

//  channel   direction  handshake                fields
//  in_       in         in_valid / in_stall      operation, rates, accels, new_heading
//  out_      out        out_valid / out_stall    heading, heading_step, calibrated
//  cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  a load item goes straight to the output stage; a calibration sample squares
//  each accel axis; the sample that closes calibration adds a 70-step divide and
//  a 16-step root per axis; a tick runs the 32-step bit-serial scale multiply;
//  the divide by CAL_SAMPLES is one reciprocal multiply (skipped when saturated)
//  synchronous active-low reset clears all calibration state and the yaw
//  in_stall is high from acceptance until the result sits in the output register;
//  the output register holds while out_stall is high

module gyro_calibrate_yaw_integrate #(
  parameter int CAL_SAMPLES   = 500,
  parameter int YAW_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [24:0] in_new_heading,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [24:0] out_heading,
  output logic signed [21:0] out_heading_step,
  output logic               out_calibrated,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  // yaw working width: room for 360 degrees plus one step and a loaded value
  localparam int YW = (YAW_FRAC_BITS + 10 > 27) ? YAW_FRAC_BITS + 10 : 27;
  localparam int K  = 47 - YAW_FRAC_BITS;
  localparam logic signed [YW-1:0] HALF = YW'(longint'(180) <<< YAW_FRAC_BITS);
  localparam logic signed [YW-1:0] FULL = YW'(longint'(360) <<< YAW_FRAC_BITS);
  localparam logic [75:0] SAT_THR =
    76'(longint'(CAL_SAMPLES) * longint'(gcyi_pkg::STEP_LIMIT + 1)) << K;
  localparam logic signed [16:0] N_MUL = 17'(CAL_SAMPLES);
  localparam logic [10:0] N_CMP = 11'(CAL_SAMPLES);
  // reciprocal of CAL_SAMPLES, exact for unsaturated dividends below 2^30
  localparam int RSH = 30 + $clog2(CAL_SAMPLES);
  localparam logic [31:0] RECIP =
    32'(((longint'(1) <<< RSH) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES));

  gcyi_pkg::state_t state_r, state_nxt;

  // configuration
  logic [31:0] scale_r;
  logic        flat_r;

  // calibration state
  logic [9:0]         ctr_r;
  logic               cal_r;
  logic signed [25:0] zsum_r;
  logic signed [15:0] zlow_r, zhigh_r;
  logic [39:0]        acs_r [3];
  logic [15:0]        grav_r [3];
  logic signed [YW-1:0] yaw_r;

  // captured item
  logic signed [15:0] rx_r, ry_r, rz_r;
  logic signed [15:0] ac_r [3];

  // sequencer
  logic [1:0]         axis_r;
  logic [gcyi_pkg::CNT_W-1:0] cnt_r;
  logic [41:0]        tot_r;

  // tick datapath
  logic signed [26:0] tmp_r, dz_r;
  logic signed [44:0] acc_r;
  logic [42:0]        mc_r;
  logic               neg_r;
  logic [43:0]        ph_r;
  logic [31:0]        pl_r;
  logic signed [21:0] step_r;

  // shared long divider
  logic [gcyi_pkg::DVD_W-1:0] dvd_r;
  logic [gcyi_pkg::DVS_W-1:0] dvs_r, rem_r;
  logic [gcyi_pkg::QUO_W-1:0] quo_r;

  // shared square root
  logic [31:0] sx_r, sr_r, sb_r;

  // output register
  logic               ov_r;
  logic signed [24:0] oh_r;
  logic signed [21:0] os_r;
  logic               oc_r;

  // shared multiplier
  logic signed [26:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [43:0] mul_p;

  logic               in_acc, out_free;
  logic [42:0]        rem2;
  logic               div_ge;
  logic [31:0]        sq_trial;
  logic               sq_ge;
  logic [44:0]        sc_sum;
  logic [75:0]        prod_w, prod_sh;
  logic [61:0]        rcp_p;
  logic [21:0]        q22;
  logic signed [21:0] step_val;
  logic signed [YW-1:0] yaw_dec;
  logic               outside;

  function automatic logic signed [YW-1:0] wrap_yaw(input logic signed [YW-1:0] y);
    logic signed [YW-1:0] r;
    r = y;
    if (y > HALF) r = y - FULL;
    else if (y < -HALF) r = y + FULL;
    return r;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      gcyi_pkg::S_CAL_SQ: begin
        mul_a = 27'(ac_r[axis_r]);
        mul_b = 17'(ac_r[axis_r]);
      end
      gcyi_pkg::S_T_DZ0: begin
        mul_a = 27'(rz_r);
        mul_b = N_MUL;
      end
      gcyi_pkg::S_T_X0: begin
        mul_a = 27'(rx_r);
        mul_b = N_MUL;
      end
      gcyi_pkg::S_T_Y0: begin
        mul_a = 27'(ry_r);
        mul_b = N_MUL;
      end
      gcyi_pkg::S_T_X1: begin
        mul_a = tmp_r;
        mul_b = signed'({1'b0, grav_r[0]});
      end
      gcyi_pkg::S_T_Y1: begin
        mul_a = tmp_r;
        mul_b = signed'({1'b0, grav_r[1]});
      end
      gcyi_pkg::S_T_Z: begin
        mul_a = dz_r;
        mul_b = signed'({1'b0, grav_r[2]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider, root and scale-multiply steps
  assign rem2     = {rem_r, dvd_r[gcyi_pkg::DVD_W-1]};
  assign div_ge   = rem2 >= {1'b0, dvs_r};
  assign sq_trial = sr_r + sb_r;
  assign sq_ge    = sx_r >= sq_trial;
  assign sc_sum   = {1'b0, ph_r} + (pl_r[0] ? {2'b0, mc_r} : 45'd0);
  assign prod_w   = {ph_r, pl_r};
  assign prod_sh  = prod_w >> K;
  assign rcp_p    = 62'(prod_sh[29:0]) * 62'(RECIP);
  assign q22      = quo_r[21:0];
  assign step_val = neg_r ? -signed'(q22) : signed'(q22);
  assign yaw_dec  = yaw_r - YW'(step_val);
  assign outside  = (rz_r < zlow_r) || (rz_r > zhigh_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcyi_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_operation == gcyi_pkg::OP_LOAD) state_nxt = gcyi_pkg::S_DONE;
          else if (cal_r) state_nxt = gcyi_pkg::S_T_DZ0;
          else state_nxt = gcyi_pkg::S_CAL_SQ;
        end
      end
      gcyi_pkg::S_CAL_SQ:
        if (axis_r == 2'd2) state_nxt = gcyi_pkg::S_CAL_TOT;
      gcyi_pkg::S_CAL_TOT:
        state_nxt = ({1'b0, ctr_r} >= N_CMP) ? gcyi_pkg::S_CAL_AX : gcyi_pkg::S_DONE;
      gcyi_pkg::S_CAL_AX: begin
        if (tot_r != '0) state_nxt = gcyi_pkg::S_CAL_DIV;
        else if (axis_r == 2'd2) state_nxt = gcyi_pkg::S_DONE;
      end
      gcyi_pkg::S_CAL_DIV:
        if (cnt_r == 7'd1) state_nxt = gcyi_pkg::S_CAL_SQRT;
      gcyi_pkg::S_CAL_SQRT:
        if (cnt_r == 7'd1) begin
          state_nxt = (axis_r == 2'd2) ? gcyi_pkg::S_DONE : gcyi_pkg::S_CAL_AX;
        end
      gcyi_pkg::S_T_DZ0:  state_nxt = gcyi_pkg::S_T_DZ1;
      gcyi_pkg::S_T_DZ1:  state_nxt = flat_r ? gcyi_pkg::S_T_FLAT : gcyi_pkg::S_T_X0;
      gcyi_pkg::S_T_FLAT: state_nxt = gcyi_pkg::S_T_ABS;
      gcyi_pkg::S_T_X0:   state_nxt = gcyi_pkg::S_T_X1;
      gcyi_pkg::S_T_X1:   state_nxt = gcyi_pkg::S_T_Y0;
      gcyi_pkg::S_T_Y0:   state_nxt = gcyi_pkg::S_T_Y1;
      gcyi_pkg::S_T_Y1:   state_nxt = gcyi_pkg::S_T_Z;
      gcyi_pkg::S_T_Z:    state_nxt = gcyi_pkg::S_T_ABS;
      gcyi_pkg::S_T_ABS:  state_nxt = gcyi_pkg::S_T_SCALE;
      gcyi_pkg::S_T_SCALE:
        if (cnt_r == 7'd1) state_nxt = gcyi_pkg::S_T_SAT;
      gcyi_pkg::S_T_SAT:
        state_nxt = (prod_w >= SAT_THR) ? gcyi_pkg::S_T_FIN : gcyi_pkg::S_T_DIV;
      gcyi_pkg::S_T_DIV:  state_nxt = gcyi_pkg::S_T_FIN;
      gcyi_pkg::S_T_FIN:  state_nxt = gcyi_pkg::S_DONE;
      gcyi_pkg::S_DONE:
        if (out_free) state_nxt = gcyi_pkg::S_IDLE;
      default: state_nxt = gcyi_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = (state_r != gcyi_pkg::S_IDLE);
    cfg_ready = 1'b1;
    out_valid = ov_r;
  end

  assign out_heading      = oh_r;
  assign out_heading_step = os_r;
  assign out_calibrated   = oc_r;

  // control state, configuration and calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcyi_pkg::S_IDLE;
      scale_r <= gcyi_pkg::TICK_SCALE_RST;
      flat_r  <= gcyi_pkg::FLAT_MODE_RST;
      ctr_r   <= '0;
      cal_r   <= 1'b0;
      zsum_r  <= '0;
      zlow_r  <= '0;
      zhigh_r <= '0;
      yaw_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acs_r[i]  <= '0;
        grav_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gcyi_pkg::CFG_TICK_SCALE) scale_r <= cfg_data;
        else flat_r <= cfg_data[0];
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        gcyi_pkg::S_IDLE:
          if (in_acc) begin
            if (in_operation == gcyi_pkg::OP_LOAD) begin
              yaw_r <= wrap_yaw(YW'(in_new_heading));
            end else if (!cal_r) begin
              // deadband, bias sum and sample count
              if (in_rate_z > zhigh_r) zhigh_r <= in_rate_z;
              if (in_rate_z < zlow_r) zlow_r <= in_rate_z;
              zsum_r <= zsum_r + 26'(in_rate_z);
              ctr_r  <= ctr_r + 10'd1;
            end
          end
        gcyi_pkg::S_CAL_SQ:
          acs_r[axis_r] <= acs_r[axis_r] + {8'd0, mul_p[31:0]};
        gcyi_pkg::S_CAL_AX:
          if (tot_r == '0) begin
            grav_r[axis_r] <= '0;
            if (axis_r == 2'd2) cal_r <= 1'b1;
          end
        gcyi_pkg::S_CAL_SQRT:
          if (cnt_r == 7'd1) begin
            grav_r[axis_r] <= sq_ge ? 16'((sr_r >> 1) + sb_r) : 16'(sr_r >> 1);
            if (axis_r == 2'd2) cal_r <= 1'b1;
          end
        gcyi_pkg::S_T_FIN:
          yaw_r <= wrap_yaw(yaw_dec);
        gcyi_pkg::S_DONE:
          if (out_free) ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload datapath
  always_ff @(posedge clk) begin
    case (state_r)
      gcyi_pkg::S_IDLE:
        if (in_acc) begin
          rx_r    <= in_rate_x;
          ry_r    <= in_rate_y;
          rz_r    <= in_rate_z;
          ac_r[0] <= in_accel_x;
          ac_r[1] <= in_accel_y;
          ac_r[2] <= in_accel_z;
          axis_r  <= 2'd0;
          step_r  <= '0;
        end
      gcyi_pkg::S_CAL_SQ:
        axis_r <= axis_r + 2'd1;
      gcyi_pkg::S_CAL_TOT: begin
        tot_r  <= {2'b0, acs_r[0]} + {2'b0, acs_r[1]} + {2'b0, acs_r[2]};
        axis_r <= 2'd0;
      end
      gcyi_pkg::S_CAL_AX:
        if (tot_r != '0) begin
          // floor(S * 2^30 / total)
          dvd_r <= {acs_r[axis_r], 30'd0};
          dvs_r <= tot_r;
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= gcyi_pkg::CNT_W'(gcyi_pkg::RATIO_IT);
        end else begin
          axis_r <= axis_r + 2'd1;
        end
      gcyi_pkg::S_CAL_DIV: begin
        dvd_r <= dvd_r << 1;
        rem_r <= div_ge ? 42'(rem2 - {1'b0, dvs_r}) : rem2[41:0];
        quo_r <= {quo_r[gcyi_pkg::QUO_W-2:0], div_ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          // start the root on the finished quotient
          sx_r  <= {1'b0, quo_r[gcyi_pkg::QUO_W-2:0], div_ge};
          sr_r  <= '0;
          sb_r  <= 32'h4000_0000;
          cnt_r <= gcyi_pkg::CNT_W'(gcyi_pkg::SQRT_IT);
        end
      end
      gcyi_pkg::S_CAL_SQRT: begin
        if (sq_ge) begin
          sx_r <= sx_r - sq_trial;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r  <= sb_r >> 2;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) axis_r <= axis_r + 2'd1;
      end
      gcyi_pkg::S_T_DZ0:
        tmp_r <= mul_p[26:0];
      gcyi_pkg::S_T_DZ1:
        dz_r <= outside ? tmp_r - 27'(zsum_r) : 27'd0;
      gcyi_pkg::S_T_FLAT:
        acc_r <= 45'(dz_r) <<< 15;
      gcyi_pkg::S_T_X0, gcyi_pkg::S_T_Y0:
        tmp_r <= mul_p[26:0];
      gcyi_pkg::S_T_X1:
        acc_r <= 45'(mul_p);
      gcyi_pkg::S_T_Y1, gcyi_pkg::S_T_Z:
        acc_r <= acc_r + 45'(mul_p);
      gcyi_pkg::S_T_ABS: begin
        neg_r <= acc_r[44];
        mc_r  <= acc_r[44] ? 43'(-acc_r) : acc_r[42:0];
        ph_r  <= '0;
        pl_r  <= scale_r;
        cnt_r <= gcyi_pkg::CNT_W'(gcyi_pkg::SCALE_IT);
      end
      gcyi_pkg::S_T_SCALE: begin
        ph_r  <= sc_sum[44:1];
        pl_r  <= {sc_sum[0], pl_r[31:1]};
        cnt_r <= cnt_r - 7'd1;
      end
      gcyi_pkg::S_T_SAT:
        if (prod_w >= SAT_THR) quo_r <= gcyi_pkg::QUO_W'(gcyi_pkg::STEP_LIMIT);
      gcyi_pkg::S_T_DIV:
        // divide by CAL_SAMPLES through the reciprocal
        quo_r <= gcyi_pkg::QUO_W'(rcp_p >> RSH);
      gcyi_pkg::S_T_FIN:
        step_r <= step_val;
      gcyi_pkg::S_DONE:
        if (out_free) begin
          oh_r <= yaw_r[24:0];
          os_r <= step_r;
          oc_r <= cal_r;
        end
      default: ;
    endcase
  end

  // checks
  a_step_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r != '0) |-> oc_r)
    else $error("nonzero yaw step before calibration");

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |=> cal_r)
    else $error("calibrated flag dropped");

  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (os_r <= 22'sd1048576 && os_r >= -22'sd1048576))
    else $error("yaw step beyond saturation limit");

  a_grav_unit: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |-> (grav_r[0] <= 16'd32768 && grav_r[1] <= 16'd32768
               && grav_r[2] <= 16'd32768))
    else $error("gravity component above unit");

endmodule

### dv/gyro_calibrate_yaw_integrate_test.sv
`timescale 1ns / 1ps
// self-checking testbench for gyro_calibrate_yaw_integrate: calibration, ticks, yaw loads
// depends on gcyi_pkg and the block's rtl

module gyro_calibrate_yaw_integrate_test;

  localparam int CAL_N     = 500;
  localparam int FRAC      = 16;
  localparam int WDOG_MAX  = 20000;
  localparam longint HALF_TURN = longint'(180) <<< FRAC;
  localparam longint FULL_TURN = longint'(360) <<< FRAC;

  // one input request
  typedef struct {
    logic               op;
    logic signed [15:0] rx, ry, rz;
    logic signed [15:0] ax, ay, az;
    logic signed [24:0] hdg;
  } imu_req_t;

  // one result
  typedef struct {
    logic signed [24:0] heading;
    logic signed [21:0] step;
    logic               cal;
  } yaw_res_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_operation;
  logic signed [15:0] in_rate_x, in_rate_y, in_rate_z;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [24:0] in_new_heading;
  logic out_valid, out_stall, out_calibrated;
  logic signed [24:0] out_heading;
  logic signed [21:0] out_heading_step;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;

  gyro_calibrate_yaw_integrate DUT (.*);

  // stimulus waiting for the driver, results waiting for the monitor
  imu_req_t imu_pending[$];
  yaw_res_t yaw_due[$];

  // predictor copy of registers and state
  logic [31:0]        scale_q;
  logic               flat_q;
  int                 cal_count;
  logic               cal_done;
  longint             z_sum, z_low, z_high;
  longint unsigned    sq_sum[3];
  logic [15:0]        grav[3];
  longint             yaw;

  int  errors, n_loads, n_cal, n_ticks, n_sat, n_moved, n_results;
  bit  calm;          // no idling in the last part of the run
  bit  pressure_done;
  int  wdog;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint wrap_deg(longint y);
    if (y > HALF_TURN) return y - FULL_TURN;
    if (y < -HALF_TURN) return y + FULL_TURN;
    return y;
  endfunction

  // floor square root, result fits 16 bits for inputs up to 2^30
  function automatic logic [15:0] floor_sqrt(longint unsigned x);
    logic [15:0] r;
    logic [15:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (16'd1 << b);
      if (longint'(t) * longint'(t) <= x) r = t;
    end
    return r;
  endfunction

  // expected result of one accepted request, advancing the predictor state
  function automatic yaw_res_t advance_heading(imu_req_t q);
    yaw_res_t        r;
    longint          rz, dz, acc, step;
    longint unsigned mag, tot, quo;
    logic [127:0]    prod, frac30;
    rz = q.rz;
    step = 0;
    if (q.op == gcyi_pkg::OP_LOAD) begin
      yaw = wrap_deg(longint'(q.hdg));
      n_loads++;
    end else if (!cal_done) begin
      if (rz > z_high) z_high = rz;
      if (rz < z_low) z_low = rz;
      z_sum += rz;
      sq_sum[0] += longint'(q.ax) * longint'(q.ax);
      sq_sum[1] += longint'(q.ay) * longint'(q.ay);
      sq_sum[2] += longint'(q.az) * longint'(q.az);
      cal_count++;
      n_cal++;
      if (cal_count >= CAL_N) begin
        // normalized gravity direction, Q15
        tot = sq_sum[0] + sq_sum[1] + sq_sum[2];
        for (int i = 0; i < 3; i++) begin
          if (tot == 0) grav[i] = '0;
          else begin
            frac30 = (128'(sq_sum[i]) << 30) / 128'(tot);
            grav[i] = floor_sqrt(longint'(frac30[63:0]));
          end
        end
        cal_done = 1'b1;
      end
    end else begin
      dz = 0;
      if (rz < z_low || rz > z_high) dz = rz * CAL_N - z_sum;
      if (flat_q) acc = dz * 32768;
      else acc = longint'(q.rx) * CAL_N * longint'({1'b0, grav[0]})
               + longint'(q.ry) * CAL_N * longint'({1'b0, grav[1]})
               + dz * longint'({1'b0, grav[2]});
      mag = (acc < 0) ? longint'(-acc) : acc;
      prod = 128'(mag) * 128'(scale_q);
      prod = (prod >> (47 - FRAC)) / CAL_N;
      quo = (prod > gcyi_pkg::STEP_LIMIT) ? gcyi_pkg::STEP_LIMIT : prod[63:0];
      if (quo == gcyi_pkg::STEP_LIMIT) n_sat++;
      if (quo != 0) n_moved++;
      step = (acc < 0) ? -longint'(quo) : longint'(quo);
      yaw = wrap_deg(yaw - step);
      n_ticks++;
    end
    r.heading = yaw[24:0];
    r.step    = step[21:0];
    r.cal     = cal_done;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, random idle bursts between them
  // ---------------------------------------------------------------------------
  imu_req_t cur_req;
  int       in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      // accepted this edge: predict from the request just taken
      if (in_valid && !in_stall) yaw_due.push_back(advance_heading(cur_req));
      // a stalled request stays put; otherwise pick the next action
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (imu_pending.size() > 0) begin
          cur_req = imu_pending.pop_front();
          in_operation   <= cur_req.op;
          in_rate_x      <= cur_req.rx;
          in_rate_y      <= cur_req.ry;
          in_rate_z      <= cur_req.rz;
          in_accel_x     <= cur_req.ax;
          in_accel_y     <= cur_req.ay;
          in_accel_z     <= cur_req.az;
          in_new_heading <= cur_req.hdg;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall: random bursts plus one long hold to back up the block
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      pressure_done = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!pressure_done && n_results >= 100 && imu_pending.size() >= 20) begin
      // long hold while the sender keeps offering
      pressure_done = 1'b1;
      stall_left = 400;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  yaw_res_t exp_res;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (yaw_due.size() == 0) begin
        $display("%t unexpected result heading=%0d step=%0d", $time, out_heading,
                 out_heading_step);
        errors++;
      end else begin
        exp_res = yaw_due.pop_front();
        if (out_heading !== exp_res.heading) begin
          $display("%t heading mismatch: expected %0d actual %0d", $time,
                   exp_res.heading, out_heading);
          errors++;
        end
        if (out_heading_step !== exp_res.step) begin
          $display("%t heading_step mismatch: expected %0d actual %0d", $time,
                   exp_res.step, out_heading_step);
          errors++;
        end
        if (out_calibrated !== exp_res.cal) begin
          $display("%t calibrated mismatch: expected %0d actual %0d", $time,
                   exp_res.cal, out_calibrated);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) wdog <= 0;
    else if (wdog >= WDOG_MAX) begin
      $display("%t watchdog expired, %0d results outstanding", $time, yaw_due.size());
      $display("== FAIL ==");
      $finish;
    end else wdog <= wdog + 1;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic imu_req_t mk_load(logic signed [24:0] h);
    imu_req_t q;
    q.op = gcyi_pkg::OP_LOAD;
    q.rx = 16'($urandom); q.ry = 16'($urandom); q.rz = 16'($urandom);
    q.ax = 16'($urandom); q.ay = 16'($urandom); q.az = 16'($urandom);
    q.hdg = h;
    return q;
  endfunction

  function automatic imu_req_t mk_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                                         logic signed [15:0] rz);
    imu_req_t q;
    q.op = gcyi_pkg::OP_SAMPLE;
    q.rx = rx; q.ry = ry; q.rz = rz;
    q.ax = 16'($urandom); q.ay = 16'($urandom); q.az = 16'($urandom);
    q.hdg = 25'($urandom);
    return q;
  endfunction

  // random heading: mostly in range, sometimes anywhere in the 25-bit field
  function automatic logic signed [24:0] rand_heading();
    if ($urandom_range(0, 3) == 0) return 25'($urandom);
    return 25'($signed($urandom_range(0, 23592960)) - 11796480);
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gcyi_pkg::CFG_TICK_SCALE) scale_q = val;
    else flat_q = val[0];
  endtask

  // wait until everything queued has come back, then let the block settle
  task automatic drain();
    @(posedge clk);
    while (imu_pending.size() > 0 || yaw_due.size() > 0 || in_valid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one phase of integration ticks, with some yaw loads mixed in
  task automatic tick_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) imu_pending.push_back(mk_load(rand_heading()));
      else if ($urandom_range(0, 2) == 0)
        imu_pending.push_back(mk_sample(16'($urandom), 16'($urandom),
                                        16'($signed($urandom_range(0, 120)) - 60)));
      else imu_pending.push_back(mk_sample(16'($urandom), 16'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_operation = gcyi_pkg::OP_SAMPLE;
    in_rate_x = '0; in_rate_y = '0; in_rate_z = '0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0; in_new_heading = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = gcyi_pkg::CFG_TICK_SCALE; cfg_data = '0;
    scale_q = gcyi_pkg::TICK_SCALE_RST; flat_q = gcyi_pkg::FLAT_MODE_RST;
    cal_count = 0; cal_done = 1'b0; z_sum = 0; z_low = 0; z_high = 0;
    for (int i = 0; i < 3; i++) begin
      sq_sum[i] = 0;
      grav[i] = '0;
    end
    yaw = 0;
    errors = 0; n_loads = 0; n_cal = 0; n_ticks = 0; n_sat = 0; n_moved = 0;
    n_results = 0; calm = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(gcyi_pkg::CFG_FLAT_MODE, 32'd0);
    write_reg(gcyi_pkg::CFG_TICK_SCALE, 32'hFFFF_FFFF);

    // loads during calibration, including values that need wrapping
    imu_pending.push_back(mk_load(25'sd11796480));
    imu_pending.push_back(mk_load(-25'sd11796480));
    imu_pending.push_back(mk_load(25'sd11796481));
    imu_pending.push_back(mk_load(-25'sd11796481));
    imu_pending.push_back(mk_load(25'sd16777215));
    imu_pending.push_back(mk_load(-25'sd16777216));
    imu_pending.push_back(mk_load(25'sd0));
    // calibration samples: field extremes on x/y and accel, z pinned to known band edges
    begin
      imu_req_t q;
      q = mk_sample(16'sh7FFF, -16'sh8000, 16'sd40);
      q.ax = 16'sh7FFF; q.ay = -16'sh8000; q.az = 16'sd0;
      imu_pending.push_back(q);
      q = mk_sample(-16'sh8000, 16'sh7FFF, -16'sd40);
      q.ax = -16'sh8000; q.ay = 16'sd0; q.az = 16'sh7FFF;
      imu_pending.push_back(q);
    end
    // rest of calibration: small z-rate so the deadband stays narrow
    for (int i = 2; i < CAL_N; i++) begin
      if ($urandom_range(0, 24) == 0) imu_pending.push_back(mk_load(rand_heading()));
      imu_pending.push_back(mk_sample(16'($urandom), 16'($urandom),
                                      16'($signed($urandom_range(0, 80)) - 40)));
    end
    drain();

    // saturating scale, flat: extremes and deadband edges
    write_reg(gcyi_pkg::CFG_FLAT_MODE, 32'd1);
    imu_pending.push_back(mk_sample('0, '0, 16'sh7FFF));
    imu_pending.push_back(mk_sample('0, '0, -16'sh8000));
    imu_pending.push_back(mk_sample('0, '0, 16'sd40));
    imu_pending.push_back(mk_sample('0, '0, -16'sd40));
    imu_pending.push_back(mk_sample('0, '0, 16'sd41));
    imu_pending.push_back(mk_sample('0, '0, -16'sd41));
    tick_phase(70);
    drain();

    write_reg(gcyi_pkg::CFG_TICK_SCALE, 32'd0);
    tick_phase(40);
    drain();

    // tilted, reset scale
    write_reg(gcyi_pkg::CFG_FLAT_MODE, 32'd0);
    write_reg(gcyi_pkg::CFG_TICK_SCALE, gcyi_pkg::TICK_SCALE_RST);
    imu_pending.push_back(mk_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    imu_pending.push_back(mk_sample(-16'sh8000, -16'sh8000, -16'sh8000));
    imu_pending.push_back(mk_sample(16'sd0, 16'sd0, 16'sd0));
    tick_phase(90);
    drain();

    write_reg(gcyi_pkg::CFG_TICK_SCALE, $urandom);
    tick_phase(90);
    drain();

    // last part: flat, random scale, no idling on either side
    calm = 1'b1;
    write_reg(gcyi_pkg::CFG_FLAT_MODE, 32'd1);
    write_reg(gcyi_pkg::CFG_TICK_SCALE, $urandom_range(0, 32'h00FF_FFFF));
    tick_phase(90);
    drain();
    repeat (300) @(posedge clk);

    $display("covered %0d calibration samples, %0d ticks (%0d moved, %0d saturated), %0d loads",
             n_cal, n_ticks, n_moved, n_sat, n_loads);
    $display("%0d results checked, %0d mismatches", n_results, errors);
    if (errors == 0 && yaw_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/gcyi_pkg.sv
rtl/gyro_calibrate_yaw_integrate.sv
dv/gyro_calibrate_yaw_integrate_test.sv
